// ===== src/binary_image_rectangle_finder_assert.svh =====
// assertion macros used by the rectangle finder checker
`ifndef BINARY_IMAGE_RECTANGLE_FINDER_ASSERT_SVH
`define BINARY_IMAGE_RECTANGLE_FINDER_ASSERT_SVH

// condition holds in the same cycle as the trigger, checked out of reset
`define BIRF_ASSERT_SAME(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error(msg);

// condition holds in the cycle after the trigger, checked out of reset
`define BIRF_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

// condition holds in the cycle after reset is seen low
`define BIRF_ASSERT_AFTER_RESET(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (prop)) \
        else $error(msg);

`endif

// ===== src/birf_pkg.sv =====
// shared types and constants of the binary image rectangle finder
package birf_pkg;

    // frame size limits and register reset value
    localparam int MAX_ROWS_DEFAULT = 1024;
    localparam int MAX_COLS_DEFAULT = 1024;
    localparam int COUNT_RESET      = 1024;

    // field widths
    localparam int COUNT_W     = 11;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int INDEX_W     = 19;
    localparam int CFG_INDEX_W = 2;

    // result queue sizing
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = FIFO_PTR_W + 1;
    localparam int FIFO_HEADROOM = 4;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_COUNT = 2'd0,
        REG_COL_COUNT = 2'd1
    } cfg_reg_t;

    // column record sweep control
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } sweep_state_t;

    // one rectangle result
    typedef struct packed {
        logic [ROW_W-1:0]   corner_row;
        logic [COL_W-1:0]   corner_col;
        logic [SIZE_W-1:0]  rect_width;
        logic [SIZE_W-1:0]  rect_height;
        logic [INDEX_W-1:0] rect_index;
        logic               last;
    } rect_result_t;

    // queue write strobes, second implies first
    typedef struct packed {
        logic first;
        logic second;
    } fifo_push_t;

endpackage

// ===== src/birf_ram.sv =====
// generic simple dual port ram with registered read
module birf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same address collision
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/birf_fifo.sv =====
// result queue, up to two writes and one read per cycle
module birf_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  birf_pkg::fifo_push_t   push,
    input  birf_pkg::rect_result_t push_data0,
    input  birf_pkg::rect_result_t push_data1,
    output logic                   has_room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output birf_pkg::rect_result_t out_data
);
    import birf_pkg::*;

    rect_result_t          slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_PTR_W-1:0] tail_plus1;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            push_n;
    logic                  pop;

    // output side
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[head_reg];
    assign pop       = out_valid && out_ready;

    // room for the item at work and one more
    assign has_room = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_HEADROOM));

    // pointer and fill arithmetic
    assign tail_plus1 = tail_reg + 1'b1;
    assign push_n     = {1'b0, push.first} + {1'b0, push.second};

    always_comb begin
        head_next  = pop ? (head_reg + 1'b1) : head_reg;
        tail_next  = tail_reg + FIFO_PTR_W'(push_n);
        count_next = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.first) begin
            slot_reg[tail_reg] <= push_data0;
        end
        if (push.second) begin
            slot_reg[tail_plus1] <= push_data1;
        end
    end

endmodule

// ===== src/binary_image_rectangle_finder.sv =====
// binary image rectangle finder, top level
//
//  channel  | direction | transfer carries
//  ---------+-----------+-------------------------------------------------
//  s_       | in        | one pixel in raster order
//  m_       | out       | one rectangle: corner, width, height, index, last
//  cfg_     | in        | register index and data (row count, col count)
//
// One pixel per cycle unless stalled: a pixel reads its column entry from the
// column ram in the cycle of its transfer and writes it back the next cycle.
// A pixel gives up to two results, queued in an eight entry result buffer;
// s_ready drops while the buffer holds more than four results.
// After reset and after each register write the column records are cleared
// by a sweep over all MAX_COLS column entries, during which s_ready is low.
module binary_image_rectangle_finder #(
    parameter int MAX_ROWS = birf_pkg::MAX_ROWS_DEFAULT,
    parameter int MAX_COLS = birf_pkg::MAX_COLS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [birf_pkg::ROW_W-1:0]       m_corner_row,
    output logic [birf_pkg::COL_W-1:0]       m_corner_col,
    output logic [birf_pkg::SIZE_W-1:0]      m_rect_width,
    output logic [birf_pkg::SIZE_W-1:0]      m_rect_height,
    output logic [birf_pkg::INDEX_W-1:0]     m_rect_index,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [birf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [birf_pkg::COUNT_W-1:0]     cfg_data
);
    import birf_pkg::*;

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CRW    = (RW < SIZE_W) ? RW : SIZE_W;
    localparam int STAT_W = CRW + 2;
    localparam int CAP_W  = COUNT_W + 1;

    localparam int ROW_CAP_I = (MAX_ROWS > 2 ** COUNT_W) ? 2 ** COUNT_W : MAX_ROWS;
    localparam int COL_CAP_I = (MAX_COLS > 2 ** COUNT_W) ? 2 ** COUNT_W : MAX_COLS;
    localparam logic [CAP_W-1:0] ROW_CAP = CAP_W'(ROW_CAP_I);
    localparam logic [CAP_W-1:0] COL_CAP = CAP_W'(COL_CAP_I);
    localparam logic [RW-1:0] ROW_LAST_RST =
        RW'(((COUNT_RESET < MAX_ROWS) ? COUNT_RESET : MAX_ROWS) - 1);
    localparam logic [CW-1:0] COL_LAST_RST =
        CW'(((COUNT_RESET < MAX_COLS) ? COUNT_RESET : MAX_COLS) - 1);
    localparam logic [CW-1:0] CLEAR_LAST = CW'(MAX_COLS - 1);

    // configuration
    logic [RW-1:0]    row_last_reg;
    logic [CW-1:0]    col_last_reg;
    logic             cfg_xfer;
    logic             cfg_row_hit, cfg_col_hit, cfg_hit;
    logic [CAP_W-1:0] cfg_ext;
    logic [CAP_W-1:0] row_last_cap, col_last_cap;

    // sweep
    sweep_state_t  state_reg, state_next;
    logic [CW-1:0] clear_addr_reg;
    logic          sweeping;

    // raster position, pixel transfer stage
    logic [RW-1:0] row_pos_reg;
    logic [CW-1:0] col_pos_reg;
    logic          s_xfer;
    logic          at_last_row, at_last_col;

    // work stage
    logic          s1_valid_reg;
    logic          s1_pixel_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_last_row_reg, s1_last_col_reg;

    // run and frame state
    logic               left_reg;
    logic               run_open_reg, run_corner_reg;
    logic [CW-1:0]      run_start_reg;
    logic [INDEX_W-1:0] rect_cnt_reg, rect_cnt_next;

    // memories and forwarding
    logic              stat_we, width_we;
    logic [CW-1:0]     stat_waddr, width_waddr;
    logic [STAT_W-1:0] stat_wdata, stat_rdata, stat_cur;
    logic [SIZE_W-1:0] width_wdata, width_rdata, width_cur;
    logic              stat_fwd_en_reg, width_fwd_en_reg;
    logic [CW-1:0]     stat_fwd_addr_reg, width_fwd_addr_reg;
    logic [STAT_W-1:0] stat_fwd_data_reg;
    logic [SIZE_W-1:0] width_fwd_data_reg;

    // work stage decode
    logic              rec_up, rec_active;
    logic [CRW-1:0]    rec_crow;
    logic              up_eff, corner, run_begin, close_col;
    logic              run_open_cur, run_corner_cur;
    logic [CW-1:0]     run_start_cur;
    logic              run_end, set_record;
    logic              has_a, has_b;
    logic [SIZE_W-1:0] col_height, row_width;
    logic              rec_active_new;
    logic [CRW-1:0]    rec_crow_new;
    rect_result_t      res_a, res_b;
    fifo_push_t        push;
    rect_result_t      push_data0;
    logic              fifo_room;
    rect_result_t      out_data;

    // register write decode
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_ext   = {1'b0, cfg_data};

    always_comb begin
        cfg_row_hit = 1'b0;
        cfg_col_hit = 1'b0;
        unique case (cfg_index)
            REG_ROW_COUNT: cfg_row_hit = cfg_xfer;
            REG_COL_COUNT: cfg_col_hit = cfg_xfer;
            default: begin
                cfg_row_hit = 1'b0;
                cfg_col_hit = 1'b0;
            end
        endcase
    end
    assign cfg_hit = cfg_row_hit || cfg_col_hit;

    // clamp a written count to the frame limits, kept as last index
    always_comb begin
        if (cfg_ext == '0) begin
            row_last_cap = '0;
            col_last_cap = '0;
        end else begin
            row_last_cap = (cfg_ext > ROW_CAP) ? (ROW_CAP - 1'b1) : (cfg_ext - 1'b1);
            col_last_cap = (cfg_ext > COL_CAP) ? (COL_CAP - 1'b1) : (cfg_ext - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_last_reg <= ROW_LAST_RST;
            col_last_reg <= COL_LAST_RST;
        end else begin
            if (cfg_row_hit) begin
                row_last_reg <= RW'(row_last_cap);
            end
            if (cfg_col_hit) begin
                col_last_reg <= CW'(col_last_cap);
            end
        end
    end

    // sweep state, next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clear_addr_reg == CLEAR_LAST) state_next = ST_RUN;
            ST_RUN:   state_next = ST_RUN;
            default:  state_next = ST_CLEAR;
        endcase
        if (cfg_hit) begin
            state_next = ST_CLEAR;
        end
    end

    // sweep state, outputs
    always_comb begin
        sweeping = 1'b0;
        s_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: sweeping = 1'b1;
            ST_RUN:   s_ready  = fifo_room;
            default: begin
                sweeping = 1'b0;
                s_ready  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_hit) begin
                clear_addr_reg <= '0;
            end else if (sweeping) begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
            end
        end
    end

    // raster position, advanced at each pixel transfer
    assign s_xfer      = s_valid && s_ready;
    assign at_last_row = (row_pos_reg == row_last_reg);
    assign at_last_col = (col_pos_reg == col_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_xfer;
            if (cfg_hit) begin
                row_pos_reg <= '0;
                col_pos_reg <= '0;
            end else if (s_xfer) begin
                if (at_last_col) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= at_last_row ? '0 : (row_pos_reg + 1'b1);
                end else begin
                    col_pos_reg <= col_pos_reg + 1'b1;
                end
            end
        end
    end

    // pixel and position carried into the work stage
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_pixel_reg    <= s_pixel;
            s1_row_reg      <= row_pos_reg;
            s1_col_reg      <= col_pos_reg;
            s1_last_row_reg <= at_last_row;
            s1_last_col_reg <= at_last_col;
        end
    end

    // column memories: upper pixel and open column record, corner widths
    birf_ram #(
        .WIDTH (STAT_W),
        .DEPTH (MAX_COLS)
    ) u_stat_ram (
        .aclk  (aclk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .raddr (col_pos_reg),
        .rdata (stat_rdata)
    );

    birf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_width_ram (
        .aclk  (aclk),
        .we    (width_we),
        .waddr (width_waddr),
        .wdata (width_wdata),
        .raddr (col_pos_reg),
        .rdata (width_rdata)
    );

    // forward last cycle's write over a stale read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_fwd_en_reg  <= 1'b0;
            width_fwd_en_reg <= 1'b0;
        end else begin
            stat_fwd_en_reg  <= stat_we;
            width_fwd_en_reg <= width_we;
        end
    end

    always_ff @(posedge aclk) begin
        stat_fwd_addr_reg  <= stat_waddr;
        stat_fwd_data_reg  <= stat_wdata;
        width_fwd_addr_reg <= width_waddr;
        width_fwd_data_reg <= width_wdata;
    end

    assign stat_cur  = (stat_fwd_en_reg && (stat_fwd_addr_reg == s1_col_reg))
                       ? stat_fwd_data_reg : stat_rdata;
    assign width_cur = (width_fwd_en_reg && (width_fwd_addr_reg == s1_col_reg))
                       ? width_fwd_data_reg : width_rdata;

    assign {rec_up, rec_active, rec_crow} = stat_cur;

    // neighbours, corner and column run end
    assign up_eff    = (s1_row_reg != '0) && rec_up;
    assign run_begin = s1_pixel_reg && !left_reg;
    assign corner    = run_begin && !up_eff;
    assign close_col = rec_active && (!s1_pixel_reg || s1_last_row_reg);
    assign col_height = SIZE_W'(s1_row_reg) - SIZE_W'(rec_crow) + SIZE_W'(s1_pixel_reg);

    // row run tracking
    assign run_open_cur   = run_begin || run_open_reg;
    assign run_corner_cur = run_begin ? !up_eff : run_corner_reg;
    assign run_start_cur  = run_begin ? s1_col_reg : run_start_reg;
    assign run_end        = run_open_cur && (!s1_pixel_reg || s1_last_col_reg);
    assign row_width      = SIZE_W'(s1_col_reg) - SIZE_W'(run_start_cur)
                            + SIZE_W'(s1_pixel_reg);

    // results: column completion first, then row completion
    assign has_a = close_col;
    assign has_b = run_end && run_corner_cur && s1_last_row_reg;

    always_comb begin
        res_a.corner_row  = ROW_W'(rec_crow);
        res_a.corner_col  = COL_W'(s1_col_reg);
        res_a.rect_width  = width_cur;
        res_a.rect_height = col_height;
        res_a.rect_index  = rect_cnt_reg;
        res_a.last        = !has_b;

        res_b.corner_row  = ROW_W'(s1_row_reg);
        res_b.corner_col  = COL_W'(run_start_cur);
        res_b.rect_width  = row_width;
        res_b.rect_height = SIZE_W'(1);
        res_b.rect_index  = rect_cnt_reg + INDEX_W'(has_a);
        res_b.last        = 1'b1;
    end

    assign push.first  = s1_valid_reg && (has_a || has_b);
    assign push.second = s1_valid_reg && has_a && has_b;
    assign push_data0  = has_a ? res_a : res_b;

    // column record write back, or clearing during the sweep
    assign set_record     = corner && !s1_last_row_reg;
    assign rec_active_new = (rec_active && !close_col) || set_record;
    assign rec_crow_new   = set_record ? CRW'(s1_row_reg) : rec_crow;

    assign stat_we    = s1_valid_reg || sweeping;
    assign stat_waddr = sweeping ? clear_addr_reg : s1_col_reg;
    assign stat_wdata = sweeping ? '0 : {s1_pixel_reg, rec_active_new, rec_crow_new};

    // corner width stored for the column record
    assign width_we    = s1_valid_reg && run_end && run_corner_cur && !s1_last_row_reg;
    assign width_waddr = run_start_cur;
    assign width_wdata = row_width;

    // rectangle index, cleared at the end of the frame
    always_comb begin
        rect_cnt_next = rect_cnt_reg + INDEX_W'(has_a) + INDEX_W'(has_b);
        if (s1_last_row_reg && s1_last_col_reg) begin
            rect_cnt_next = '0;
        end
    end

    // run and frame state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg       <= 1'b0;
            run_open_reg   <= 1'b0;
            run_corner_reg <= 1'b0;
            run_start_reg  <= '0;
            rect_cnt_reg   <= '0;
        end else if (cfg_hit) begin
            left_reg       <= 1'b0;
            run_open_reg   <= 1'b0;
            run_corner_reg <= 1'b0;
            run_start_reg  <= '0;
            rect_cnt_reg   <= '0;
        end else if (s1_valid_reg) begin
            left_reg       <= s1_pixel_reg && !s1_last_col_reg;
            run_open_reg   <= run_open_cur && !run_end;
            run_corner_reg <= run_corner_cur && !run_end;
            run_start_reg  <= run_start_cur;
            rect_cnt_reg   <= rect_cnt_next;
        end
    end

    // result queue and output channel
    birf_fifo u_birf_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data0 (push_data0),
        .push_data1 (res_b),
        .has_room   (fifo_room),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_corner_row  = out_data.corner_row;
    assign m_corner_col  = out_data.corner_col;
    assign m_rect_width  = out_data.rect_width;
    assign m_rect_height = out_data.rect_height;
    assign m_rect_index  = out_data.rect_index;
    assign m_last        = out_data.last;

endmodule

// ===== src/birf_checker.sv =====
// port level checker for the rectangle finder, bound to the top level
`include "binary_image_rectangle_finder_assert.svh"

module birf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [birf_pkg::ROW_W-1:0]       m_corner_row,
    input logic [birf_pkg::COL_W-1:0]       m_corner_col,
    input logic [birf_pkg::SIZE_W-1:0]      m_rect_width,
    input logic [birf_pkg::SIZE_W-1:0]      m_rect_height,
    input logic [birf_pkg::INDEX_W-1:0]     m_rect_index,
    input logic                             m_last,
    input logic                             cfg_valid,
    input logic                             cfg_ready,
    input logic [birf_pkg::CFG_INDEX_W-1:0] cfg_index
);
    import birf_pkg::*;

    // a stalled result stays offered and unchanged
    `BIRF_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_corner_row) && $stable(m_corner_col) && $stable(m_rect_width) && $stable(m_rect_height) && $stable(m_rect_index) && $stable(m_last), "stalled result changed")

    // every rectangle has at least one pixel each way
    `BIRF_ASSERT_SAME(a_size_nonzero, m_valid, (m_rect_width != '0) && (m_rect_height != '0), "rectangle of zero size")

    // a register write starts the column clearing sweep
    `BIRF_ASSERT_NEXT(a_cfg_sweep, cfg_valid && cfg_ready && ((cfg_index == REG_ROW_COUNT) || (cfg_index == REG_COL_COUNT)), !s_ready, "pixel taken right after a register write")

    // reset empties the queue and holds off pixels
    `BIRF_ASSERT_AFTER_RESET(a_reset_quiet, !m_valid && !s_ready, "activity straight after reset")

endmodule

bind binary_image_rectangle_finder birf_checker u_birf_checker (.*);
